// ===== rtl/core/cowpt_pkg.sv =====
// Shared types and constants of the copy-on-write page tracker.
package cowpt_pkg;

  localparam int PAGE_W    = 40;
  localparam int ADDR_W    = 52;
  localparam int SLOT_W    = 6;
  localparam int OSLOT_W   = 5;
  localparam int CNT6_W    = 6;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 6;

  typedef enum logic [2:0] {
    REQ_LOAD    = 3'd0,
    REQ_ARM     = 3'd1,
    REQ_FAULT   = 3'd2,
    REQ_RESTORE = 3'd3,
    REQ_RELEASE = 3'd4
  } req_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NOT_HANDLED = 3'd1,
    ST_INVALID_PAR = 3'd2,
    ST_INVALID_ST  = 3'd3,
    ST_OVERFLOW    = 3'd4
  } status_e;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_ONLY = 1'd1;

  typedef struct packed {
    logic              writable;
    logic              saved;
    logic [SLOT_W-1:0] slot;
  } flag_t;

endpackage

// ===== rtl/core/cowpt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cowpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/copy_on_write_page_tracker_top.sv =====
// Copy-on-write page tracker: page table in RAM, scan and sweep sequencer.
// Load, release and refused requests: one result the cycle after start.
// Arm: one write per loaded page in the sweep state, then the result.
// Fault and restore: one table read per cycle while scanning the loaded pages;
// restore beats come out as saved entries are found, the receiver cannot stall.
// Reset clears control state; table entries are undefined until loaded.
module copy_on_write_page_tracker_top #(
  parameter int TABLE_DEPTH = 1024,
  parameter int STORE_SLOTS = 32,
  parameter int PAGE_SHIFT  = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [2:0]                      req_type_i,
  input  logic [cowpt_pkg::ADDR_W-1:0]    guest_address_i,
  input  logic                            fault_is_write_i,
  input  logic                            cfg_we_i,
  input  logic [cowpt_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [cowpt_pkg::CFG_W-1:0]     cfg_data_i,
  output logic                            result_valid_o,
  output logic [2:0]                      status_o,
  output logic                            handled_o,
  output logic                            save_valid_o,
  output logic [cowpt_pkg::OSLOT_W-1:0]   save_slot_o,
  output logic [cowpt_pkg::PAGE_W-1:0]    page_number_o,
  output logic [cowpt_pkg::CNT6_W-1:0]    restored_count_o,
  output logic                            last_o,
  output logic                            armed_flag_o,
  output logic                            overflow_flag_o,
  output logic                            read_only_flag_o,
  output logic [cowpt_pkg::CNT6_W-1:0]    dirty_count_o,
  output logic [cowpt_pkg::CNT6_W-1:0]    capacity_o
);
  import cowpt_pkg::*;

  localparam int IDX_W = TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_SWEEP, S_SCAN} state_e;

  state_e              state_q;
  req_e                op_q;
  logic [PAGE_W-1:0]   page_q;
  logic [CNT_W-1:0]    count_q;
  logic [CNT_W-1:0]    rd_idx_q;
  logic                pend_q;
  logic [IDX_W-1:0]    pend_idx_q;
  logic [SLOT_W-1:0]   next_slot_q;
  logic [SLOT_W-1:0]   cap_q;
  logic                armed_q;
  logic                ovf_q;
  logic [CFG_W-1:0]    slots_q;
  logic                ro_q;
  logic                hold_q;
  logic [SLOT_W-1:0]   hold_slot_q;
  logic [PAGE_W-1:0]   hold_page_q;
  logic [CNT6_W-1:0]   n_q;

  logic                res_vld_q;
  status_e             status_q;
  logic                handled_q;
  logic                save_vld_q;
  logic [OSLOT_W-1:0]  save_slot_q;
  logic [PAGE_W-1:0]   page_out_q;
  logic [CNT6_W-1:0]   rcount_q;
  logic                last_q;

  logic [ADDR_W-1:0]   shifted;
  logic [PAGE_W-1:0]   page_in;
  logic                accept;
  logic                rd_more;
  logic [PAGE_W-1:0]   page_rd;
  flag_t               flag_rd;
  logic                hit;
  logic [31:0]         cap_w;
  logic                page_we;
  logic                flag_we;
  logic [IDX_W-1:0]    flag_waddr;
  flag_t               flag_wdata;
  logic [IDX_W-1:0]    raddr;

  assign shifted = guest_address_i >> PAGE_SHIFT;
  assign page_in = shifted[PAGE_W-1:0];
  assign busy    = (state_q != S_IDLE);
  assign accept  = start && !busy;
  assign rd_more = rd_idx_q < count_q;
  assign raddr   = rd_more ? rd_idx_q[IDX_W-1:0] : '0;
  assign hit     = pend_q && (page_rd == page_q);

  always_comb begin
    cap_w = 32'(slots_q);
    if (cap_w == 32'd0 || cap_w > 32'(count_q)) begin
      cap_w = 32'(count_q);
    end
    if (cap_w > 32'(STORE_SLOTS)) begin
      cap_w = 32'(STORE_SLOTS);
    end
  end

  always_comb begin
    page_we    = 1'b0;
    flag_we    = 1'b0;
    flag_waddr = pend_idx_q;
    flag_wdata = '0;
    if (state_q == S_IDLE) begin
      flag_waddr = count_q[IDX_W-1:0];
      flag_wdata.writable = 1'b1;
      if (accept && req_e'(req_type_i) == REQ_LOAD && !armed_q &&
          count_q < CNT_W'(TABLE_DEPTH)) begin
        page_we = 1'b1;
        flag_we = 1'b1;
      end
    end else if (state_q == S_SWEEP) begin
      flag_we    = 1'b1;
      flag_waddr = rd_idx_q[IDX_W-1:0];
    end else if (op_q == REQ_RESTORE) begin
      flag_we = pend_q;
    end else if (hit && !flag_rd.writable) begin
      flag_we = 1'b1;
      flag_wdata = flag_rd;
      flag_wdata.writable = 1'b1;
      if (!flag_rd.saved && next_slot_q < cap_q) begin
        flag_wdata.saved = 1'b1;
        flag_wdata.slot  = next_slot_q;
      end
    end
  end

  cowpt_ram #(.WIDTH(PAGE_W), .DEPTH(TABLE_DEPTH)) u_page_ram (
    .clk_i   (clk_i),
    .we_i    (page_we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (page_in),
    .raddr_i (raddr),
    .rdata_o (page_rd)
  );

  cowpt_ram #(.WIDTH($bits(flag_t)), .DEPTH(TABLE_DEPTH)) u_flag_ram (
    .clk_i   (clk_i),
    .we_i    (flag_we),
    .waddr_i (flag_waddr),
    .wdata_i (flag_wdata),
    .raddr_i (raddr),
    .rdata_o (flag_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= REQ_LOAD;
      page_q      <= '0;
      count_q     <= '0;
      rd_idx_q    <= '0;
      pend_q      <= 1'b0;
      pend_idx_q  <= '0;
      next_slot_q <= '0;
      cap_q       <= '0;
      armed_q     <= 1'b0;
      ovf_q       <= 1'b0;
      slots_q     <= '0;
      ro_q        <= 1'b0;
      hold_q      <= 1'b0;
      hold_slot_q <= '0;
      hold_page_q <= '0;
      n_q         <= '0;
      res_vld_q   <= 1'b0;
      status_q    <= ST_OK;
      handled_q   <= 1'b0;
      save_vld_q  <= 1'b0;
      save_slot_q <= '0;
      page_out_q  <= '0;
      rcount_q    <= '0;
      last_q      <= 1'b0;
    end else begin
      res_vld_q   <= 1'b0;
      status_q    <= ST_OK;
      handled_q   <= 1'b0;
      save_vld_q  <= 1'b0;
      save_slot_q <= '0;
      page_out_q  <= '0;
      rcount_q    <= '0;
      last_q      <= 1'b0;

      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_SLOTS) begin
          slots_q <= cfg_data_i;
        end else if (cfg_idx_i == CFG_READ_ONLY) begin
          ro_q <= cfg_data_i[0];
        end
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q     <= req_e'(req_type_i);
            page_q   <= page_in;
            rd_idx_q <= '0;
            pend_q   <= 1'b0;
            hold_q   <= 1'b0;
            n_q      <= '0;
            unique case (req_e'(req_type_i))
              REQ_LOAD: begin
                res_vld_q <= 1'b1;
                if (armed_q) begin
                  status_q <= ST_INVALID_ST;
                end else if (count_q >= CNT_W'(TABLE_DEPTH)) begin
                  status_q <= ST_INVALID_PAR;
                end else begin
                  count_q <= count_q + 1'b1;
                end
              end
              REQ_ARM: begin
                if (count_q == '0) begin
                  res_vld_q <= 1'b1;
                  status_q  <= ST_INVALID_PAR;
                end else begin
                  cap_q       <= SLOT_W'(cap_w);
                  next_slot_q <= '0;
                  ovf_q       <= 1'b0;
                  armed_q     <= 1'b1;
                  state_q     <= S_SWEEP;
                end
              end
              REQ_FAULT: begin
                if (armed_q && fault_is_write_i) begin
                  state_q <= S_SCAN;
                end else begin
                  res_vld_q <= 1'b1;
                  status_q  <= ST_NOT_HANDLED;
                end
              end
              REQ_RESTORE: begin
                if (!armed_q) begin
                  res_vld_q <= 1'b1;
                  status_q  <= ST_INVALID_ST;
                end else if (ovf_q) begin
                  res_vld_q <= 1'b1;
                  status_q  <= ST_OVERFLOW;
                end else begin
                  next_slot_q <= '0;
                  state_q     <= S_SCAN;
                end
              end
              REQ_RELEASE: begin
                res_vld_q   <= 1'b1;
                armed_q     <= 1'b0;
                count_q     <= '0;
                next_slot_q <= '0;
                ovf_q       <= 1'b0;
                cap_q       <= '0;
              end
              default: begin
                res_vld_q <= 1'b1;
                status_q  <= ST_INVALID_PAR;
              end
            endcase
          end
        end

        S_SWEEP: begin
          rd_idx_q <= rd_idx_q + 1'b1;
          if (rd_idx_q + 1'b1 >= count_q) begin
            res_vld_q <= 1'b1;
            state_q   <= S_IDLE;
          end
        end

        S_SCAN: begin
          if (rd_more) begin
            rd_idx_q   <= rd_idx_q + 1'b1;
            pend_idx_q <= rd_idx_q[IDX_W-1:0];
          end
          pend_q <= rd_more;
          if (op_q == REQ_FAULT) begin
            if (hit) begin
              res_vld_q <= 1'b1;
              handled_q <= 1'b1;
              state_q   <= S_IDLE;
              if (!flag_rd.writable && !flag_rd.saved) begin
                if (next_slot_q >= cap_q) begin
                  ovf_q <= 1'b1;
                end else begin
                  next_slot_q <= next_slot_q + 1'b1;
                  save_vld_q  <= 1'b1;
                  save_slot_q <= next_slot_q[OSLOT_W-1:0];
                  page_out_q  <= page_q;
                end
              end
            end else if (!pend_q && !rd_more) begin
              res_vld_q <= 1'b1;
              status_q  <= ST_NOT_HANDLED;
              state_q   <= S_IDLE;
            end
          end else begin
            if (pend_q && flag_rd.saved) begin
              if (hold_q) begin
                res_vld_q   <= 1'b1;
                save_vld_q  <= 1'b1;
                save_slot_q <= hold_slot_q[OSLOT_W-1:0];
                page_out_q  <= hold_page_q;
              end
              hold_q      <= 1'b1;
              hold_slot_q <= flag_rd.slot;
              hold_page_q <= page_rd;
              n_q         <= n_q + 1'b1;
            end else if (!pend_q && !rd_more) begin
              res_vld_q <= 1'b1;
              last_q    <= 1'b1;
              rcount_q  <= n_q;
              state_q   <= S_IDLE;
              if (hold_q) begin
                save_vld_q  <= 1'b1;
                save_slot_q <= hold_slot_q[OSLOT_W-1:0];
                page_out_q  <= hold_page_q;
              end
            end
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign result_valid_o   = res_vld_q;
  assign status_o         = status_q;
  assign handled_o        = handled_q;
  assign save_valid_o     = save_vld_q;
  assign save_slot_o      = save_slot_q;
  assign page_number_o    = page_out_q;
  assign restored_count_o = rcount_q;
  assign last_o           = last_q;
  assign armed_flag_o     = armed_q;
  assign overflow_flag_o  = ovf_q;
  assign read_only_flag_o = armed_q & ro_q;
  assign dirty_count_o    = next_slot_q;
  assign capacity_o       = cap_q;

endmodule

// ===== dv/copy_on_write_page_tracker_top_test.sv =====
// Self-checking testbench of the copy-on-write page tracker top level.
module copy_on_write_page_tracker_top_test;
  import cowpt_pkg::*;

  localparam int DEPTH = 1024;
  localparam int SLOTS = 32;

  typedef struct {
    logic [2:0]         status;
    logic               handled;
    logic               save_valid;
    logic [OSLOT_W-1:0] save_slot;
    logic [PAGE_W-1:0]  page_number;
    logic [CNT6_W-1:0]  restored_count;
    logic               last;
    logic               armed_flag;
    logic               overflow_flag;
    logic               read_only_flag;
    logic [CNT6_W-1:0]  dirty_count;
    logic [CNT6_W-1:0]  capacity;
  } beat_t;

  class page_tracker_scoreboard;
    logic [PAGE_W-1:0] tbl_page [DEPTH];
    logic              tbl_writable [DEPTH];
    logic              tbl_saved [DEPTH];
    logic [SLOT_W-1:0] tbl_slot [DEPTH];
    int unsigned       page_count;
    int unsigned       next_slot;
    int unsigned       eff_cap;
    logic              armed;
    logic              overflowed;
    int unsigned       slots_req;
    logic              read_only;
    beat_t             pending_beats[$];
    int                fails;

    function new();
      page_count = 0;
      next_slot = 0;
      eff_cap = 0;
      armed = 0;
      overflowed = 0;
      slots_req = 0;
      read_only = 0;
      fails = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == CFG_SLOTS) slots_req = 32'(data);
      else if (idx == CFG_READ_ONLY) read_only = data[0];
    endfunction

    function beat_t make_beat(logic [2:0] st, logic hd, logic sv,
                              logic [OSLOT_W-1:0] sl, logic [PAGE_W-1:0] pg,
                              logic [CNT6_W-1:0] cnt, logic lst);
      beat_t b;
      b.status = st;
      b.handled = hd;
      b.save_valid = sv;
      b.save_slot = sl;
      b.page_number = pg;
      b.restored_count = cnt;
      b.last = lst;
      b.armed_flag = armed;
      b.overflow_flag = overflowed;
      b.read_only_flag = armed & read_only;
      b.dirty_count = CNT6_W'(next_slot);
      b.capacity = CNT6_W'(eff_cap);
      return b;
    endfunction

    function void protect_table();
      for (int i = 0; i < page_count; i++) begin
        tbl_writable[i] = 0;
        tbl_saved[i] = 0;
        tbl_slot[i] = '0;
      end
      next_slot = 0;
    endfunction

    function void note_request(logic [2:0] req, logic [ADDR_W-1:0] addr, logic wr);
      logic [PAGE_W-1:0] pg;
      int unsigned cap;
      int idx;
      beat_t list[$];
      pg = addr[ADDR_W-1:12];
      case (req)
        REQ_LOAD: begin
          if (armed) begin
            pending_beats.push_back(make_beat(ST_INVALID_ST, 0, 0, 0, 0, 0, 0));
          end else if (page_count >= DEPTH) begin
            pending_beats.push_back(make_beat(ST_INVALID_PAR, 0, 0, 0, 0, 0, 0));
          end else begin
            tbl_page[page_count] = pg;
            tbl_writable[page_count] = 1;
            tbl_saved[page_count] = 0;
            tbl_slot[page_count] = '0;
            page_count++;
            pending_beats.push_back(make_beat(ST_OK, 0, 0, 0, 0, 0, 0));
          end
        end
        REQ_ARM: begin
          if (page_count == 0) begin
            pending_beats.push_back(make_beat(ST_INVALID_PAR, 0, 0, 0, 0, 0, 0));
          end else begin
            cap = slots_req;
            if (cap == 0 || cap > page_count) cap = page_count;
            if (cap > SLOTS) cap = SLOTS;
            eff_cap = cap;
            protect_table();
            overflowed = 0;
            armed = 1;
            pending_beats.push_back(make_beat(ST_OK, 0, 0, 0, 0, 0, 0));
          end
        end
        REQ_FAULT: begin
          idx = -1;
          if (armed && wr) begin
            for (int i = 0; i < page_count; i++) begin
              if (tbl_page[i] == pg) begin
                idx = i;
                break;
              end
            end
          end
          if (idx < 0) begin
            pending_beats.push_back(make_beat(ST_NOT_HANDLED, 0, 0, 0, 0, 0, 0));
          end else if (tbl_writable[idx]) begin
            pending_beats.push_back(make_beat(ST_OK, 1, 0, 0, 0, 0, 0));
          end else if (!tbl_saved[idx] && next_slot < eff_cap) begin
            tbl_slot[idx] = SLOT_W'(next_slot);
            tbl_saved[idx] = 1;
            tbl_writable[idx] = 1;
            next_slot++;
            pending_beats.push_back(make_beat(ST_OK, 1, 1, OSLOT_W'(next_slot - 1), pg,
                                              0, 0));
          end else begin
            if (!tbl_saved[idx]) overflowed = 1;
            tbl_writable[idx] = 1;
            pending_beats.push_back(make_beat(ST_OK, 1, 0, 0, 0, 0, 0));
          end
        end
        REQ_RESTORE: begin
          if (!armed) begin
            pending_beats.push_back(make_beat(ST_INVALID_ST, 0, 0, 0, 0, 0, 0));
          end else if (overflowed) begin
            pending_beats.push_back(make_beat(ST_OVERFLOW, 0, 0, 0, 0, 0, 0));
          end else begin
            for (int i = 0; i < page_count && list.size() < SLOTS; i++) begin
              if (tbl_saved[i]) list.push_back(make_beat(ST_OK, 0, 1,
                                                         OSLOT_W'(tbl_slot[i]),
                                                         tbl_page[i], 0, 0));
            end
            protect_table();
            if (list.size() == 0) begin
              pending_beats.push_back(make_beat(ST_OK, 0, 0, 0, 0, 0, 1));
            end else begin
              foreach (list[i]) list[i].dirty_count = CNT6_W'(next_slot);
              list[list.size()-1].restored_count = CNT6_W'(list.size());
              list[list.size()-1].last = 1;
              foreach (list[i]) pending_beats.push_back(list[i]);
            end
          end
        end
        REQ_RELEASE: begin
          armed = 0;
          page_count = 0;
          next_slot = 0;
          overflowed = 0;
          eff_cap = 0;
          pending_beats.push_back(make_beat(ST_OK, 0, 0, 0, 0, 0, 0));
        end
        default: pending_beats.push_back(make_beat(ST_INVALID_PAR, 0, 0, 0, 0, 0, 0));
      endcase
    endfunction

    function void check_result(beat_t got);
      beat_t e;
      if (pending_beats.size() == 0) begin
        $error("result beat with nothing expected");
        fails++;
        return;
      end
      e = pending_beats.pop_front();
      if (got.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, got.status); fails++;
      end
      if (got.handled !== e.handled) begin
        $error("handled exp %0d got %0d", e.handled, got.handled); fails++;
      end
      if (got.save_valid !== e.save_valid) begin
        $error("save_valid exp %0d got %0d", e.save_valid, got.save_valid); fails++;
      end
      if (got.save_slot !== e.save_slot) begin
        $error("save_slot exp %0d got %0d", e.save_slot, got.save_slot); fails++;
      end
      if (got.page_number !== e.page_number) begin
        $error("page_number exp %h got %h", e.page_number, got.page_number); fails++;
      end
      if (got.restored_count !== e.restored_count) begin
        $error("restored_count exp %0d got %0d", e.restored_count, got.restored_count);
        fails++;
      end
      if (got.last !== e.last) begin
        $error("last exp %0d got %0d", e.last, got.last); fails++;
      end
      if (got.armed_flag !== e.armed_flag) begin
        $error("armed_flag exp %0d got %0d", e.armed_flag, got.armed_flag); fails++;
      end
      if (got.overflow_flag !== e.overflow_flag) begin
        $error("overflow_flag exp %0d got %0d", e.overflow_flag, got.overflow_flag); fails++;
      end
      if (got.read_only_flag !== e.read_only_flag) begin
        $error("read_only_flag exp %0d got %0d", e.read_only_flag, got.read_only_flag);
        fails++;
      end
      if (got.dirty_count !== e.dirty_count) begin
        $error("dirty_count exp %0d got %0d", e.dirty_count, got.dirty_count); fails++;
      end
      if (got.capacity !== e.capacity) begin
        $error("capacity exp %0d got %0d", e.capacity, got.capacity); fails++;
      end
    endfunction
  endclass

  logic                 clk_i = 0;
  logic                 rst_ni = 0;
  logic                 start = 0;
  logic                 busy;
  logic [2:0]           req_type_i = '0;
  logic [ADDR_W-1:0]    guest_address_i = '0;
  logic                 fault_is_write_i = 0;
  logic                 cfg_we_i = 0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  logic                 result_valid_o;
  beat_t                mon;
  logic [OSLOT_W-1:0]   save_slot_w;
  logic [PAGE_W-1:0]    page_number_w;
  logic [CNT6_W-1:0]    restored_count_w, dirty_count_w, capacity_w;
  logic [2:0]           status_w;
  logic                 handled_w, save_valid_w, last_w, armed_w, ovf_w, ro_w;

  page_tracker_scoreboard tracker_sb = new();
  int idle_pct = 0;
  int sent = 0;
  logic [PAGE_W-1:0] pool [16];

  always #10 clk_i = ~clk_i;

  copy_on_write_page_tracker_top u_top (
    .clk_i, .rst_ni, .start, .busy, .req_type_i, .guest_address_i, .fault_is_write_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .result_valid_o,
    .status_o(status_w), .handled_o(handled_w), .save_valid_o(save_valid_w),
    .save_slot_o(save_slot_w), .page_number_o(page_number_w),
    .restored_count_o(restored_count_w), .last_o(last_w), .armed_flag_o(armed_w),
    .overflow_flag_o(ovf_w), .read_only_flag_o(ro_w), .dirty_count_o(dirty_count_w),
    .capacity_o(capacity_w)
  );

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      mon.status = status_w;
      mon.handled = handled_w;
      mon.save_valid = save_valid_w;
      mon.save_slot = save_slot_w;
      mon.page_number = page_number_w;
      mon.restored_count = restored_count_w;
      mon.last = last_w;
      mon.armed_flag = armed_w;
      mon.overflow_flag = ovf_w;
      mon.read_only_flag = ro_w;
      mon.dirty_count = dirty_count_w;
      mon.capacity = capacity_w;
      tracker_sb.check_result(mon);
    end
  end

  function automatic logic [ADDR_W-1:0] rand_addr();
    return ADDR_W'({$urandom, $urandom});
  endfunction

  task automatic send(logic [2:0] req, logic [ADDR_W-1:0] addr, logic wr);
    if ($urandom_range(99) < idle_pct) begin
      repeat ($urandom_range(1, 5)) @(negedge clk_i) start = 0;
    end
    @(negedge clk_i);
    start = 1;
    req_type_i = req;
    guest_address_i = addr;
    fault_is_write_i = wr;
    do @(posedge clk_i); while (busy);
    tracker_sb.note_request(req, addr, wr);
    sent++;
  endtask

  task automatic drain();
    @(negedge clk_i) start = 0;
    while (tracker_sb.pending_beats.size() > 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    drain();
    cfg_we_i = 1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    tracker_sb.set_reg(idx, data);
    @(negedge clk_i) cfg_we_i = 0;
  endtask

  function automatic logic [ADDR_W-1:0] pool_addr(int k);
    return {pool[k], 12'($urandom)};
  endfunction

  initial begin
    int n;
    int m;
    repeat (8) @(negedge clk_i);
    rst_ni = 1;

    send(REQ_RESTORE, 0, 0);
    send(REQ_FAULT, rand_addr(), 1);
    send(REQ_ARM, 0, 0);
    send(3'd5, rand_addr(), 1);
    send(3'd6, '0, 0);
    send(3'd7, '1, 1);
    send(REQ_LOAD, '1, 0);
    send(REQ_LOAD, '0, 1);
    send(REQ_LOAD, 52'h12345678, 0);
    send(REQ_LOAD, '1, 1);
    write_reg(CFG_READ_ONLY, 1);
    send(REQ_ARM, 0, 0);
    send(REQ_FAULT, '1, 0);
    send(REQ_FAULT, 52'h99999000, 1);
    send(REQ_FAULT, 52'hFFFFFFFFFFFFF, 1);
    send(REQ_FAULT, 52'h12345FFF, 1);
    send(REQ_FAULT, 52'h12345000, 1);
    send(REQ_LOAD, 52'h1000, 0);
    send(REQ_ARM, 0, 0);
    send(REQ_RESTORE, 0, 0);
    send(REQ_FAULT, 52'h0, 1);
    send(REQ_RESTORE, 0, 0);
    send(REQ_RESTORE, 0, 0);
    write_reg(CFG_SLOTS, 1);
    send(REQ_ARM, 0, 0);
    send(REQ_FAULT, 52'h0, 1);
    send(REQ_FAULT, 52'h12345000, 1);
    send(REQ_RESTORE, 0, 0);
    send(REQ_RELEASE, 0, 0);
    write_reg(CFG_SLOTS, 32);
    write_reg(CFG_READ_ONLY, 0);

    // fill the table, overrun it, then search deep
    for (int i = 0; i <= DEPTH; i++) send(REQ_LOAD, {28'd0, i[11:0], 12'($urandom)}, 1);
    send(REQ_ARM, 0, 0);
    send(REQ_FAULT, {28'd0, 12'd1023, 12'd0}, 1);
    send(REQ_FAULT, {28'd0, 12'd0, 12'd5}, 1);
    send(REQ_FAULT, {27'd0, 13'd1024, 12'd0}, 1);
    send(REQ_RESTORE, 0, 0);
    send(REQ_RELEASE, 0, 0);
    sent = 0;

    for (int seq = 0; sent < 260; seq++) begin
      case (seq % 4)
        0: idle_pct = 0;
        1: idle_pct = 76;
        2: idle_pct = 0;
        default: idle_pct = 37;
      endcase
      if ($urandom_range(2) == 0) begin
        n = $urandom_range(9);
        write_reg(CFG_SLOTS, n == 0 ? 0 : n == 1 ? 32 : $urandom_range(32));
      end
      if ($urandom_range(3) == 0) write_reg(CFG_READ_ONLY, $urandom_range(1));
      foreach (pool[k]) pool[k] = PAGE_W'({$urandom, $urandom});
      send(REQ_RELEASE, rand_addr(), $urandom_range(1));
      n = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(19) == 0) send($urandom_range(5, 7), rand_addr(), $urandom_range(1));
        send(REQ_LOAD, $urandom_range(7) == 0 ? rand_addr() : pool_addr($urandom_range(15)),
             $urandom_range(1));
      end
      send(REQ_ARM, rand_addr(), $urandom_range(1));
      for (int r = 0; r < 2; r++) begin
        m = $urandom_range(1, 14);
        for (int i = 0; i < m; i++) begin
          case ($urandom_range(19))
            0: send(REQ_LOAD, rand_addr(), $urandom_range(1));
            1: send(REQ_ARM, rand_addr(), $urandom_range(1));
            2: send(REQ_FAULT, rand_addr(), $urandom_range(1));
            default: send(REQ_FAULT, pool_addr($urandom_range(15)), $urandom_range(9) != 0);
          endcase
        end
        send(REQ_RESTORE, rand_addr(), $urandom_range(1));
      end
    end

    @(negedge clk_i) start = 0;
    while (tracker_sb.pending_beats.size() > 0) @(posedge clk_i);
    repeat (2100) @(posedge clk_i);
    if (tracker_sb.fails == 0 && tracker_sb.pending_beats.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
